// ----- rtl/smcp_pkg.sv -----
package smcp_pkg;

    localparam logic [7:0] CHAR_SYNC1 = 8'h31;  // '1'
    localparam logic [7:0] CHAR_SYNC2 = 8'h32;  // '2'
    localparam logic [7:0] CHAR_READ  = 8'h52;  // 'R'
    localparam logic [7:0] CHAR_RESET = 8'h45;  // 'E'
    localparam logic [7:0] CHAR_ERASE = 8'h46;  // 'F'
    localparam logic [7:0] CHAR_WRITE = 8'h57;  // 'W'

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_SYNC  = 4'd1,
        PH_ADDR0 = 4'd2,
        PH_ADDR1 = 4'd3,
        PH_ADDR2 = 4'd4,
        PH_ADDR3 = 4'd5,
        PH_LEN0  = 4'd6,
        PH_LEN1  = 4'd7,
        PH_CMD   = 4'd8,
        PH_WR0   = 4'd9,
        PH_WR1   = 4'd10,
        PH_WR2   = 4'd11,
        PH_WR3   = 4'd12
    } phase_t;

    typedef enum logic [1:0] {
        OP_NONE    = 2'd0,
        OP_ERASE   = 2'd1,
        OP_PROGRAM = 2'd2
    } pending_t;

    typedef enum logic [2:0] {
        ACT_READ    = 3'd0,
        ACT_RESET   = 3'd1,
        ACT_UNLOCK  = 3'd2,
        ACT_ERASE   = 3'd3,
        ACT_PROGRAM = 3'd4,
        ACT_LOCK    = 3'd5,
        ACT_REPLY   = 3'd6
    } action_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
        logic       flash_ok;
    } item_t;

    typedef struct packed {
        action_t     action;
        logic [31:0] mem_address;
        logic [15:0] byte_length;
        logic [31:0] word_data;
        logic        reply_ok;
        logic        last_of_run;
    } result_t;

    // results produced by one item, r0 first
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

// ----- rtl/serial_memory_command_parser.sv -----
// Serial memory command parser. Takes one transfer per cycle while in_ready is
// high, each either a received byte or a flash status, and turns complete
// frames ('1' '2', 32-bit address, 16-bit length, command) into memory action
// transfers. The input sits in a one-entry register; from there it is parsed
// once the queue has room, and its zero, one or two results go into a
// four-entry result queue. Input is taken every cycle while the queue has room
// for two results; the output port drains one result per cycle while out_ready
// is high, so under sustained load items that produce two results (erase, the
// end of a write) each hold the output port for both of their results.
module serial_memory_command_parser
    import smcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [7:0]  rx_byte,
    input  logic        flash_ok,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  action,
    output logic [31:0] mem_address,
    output logic [15:0] byte_length,
    output logic [31:0] word_data,
    output logic        reply_ok,
    output logic        last_of_run
);

    logic    item_valid_reg;
    item_t   item_reg;
    logic    room;
    logic    fire;
    push_t   push;
    result_t res;

    assign fire     = item_valid_reg && room;
    assign in_ready = !item_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            item_valid_reg <= 1'b0;
        end else if (in_ready) begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            item_reg <= '{req_type: req_type, rx_byte: rx_byte, flash_ok: flash_ok};
        end
    end

    smcp_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .push  (push)
    );

    smcp_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (fire),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (res)
    );

    assign action      = res.action;
    assign mem_address = res.mem_address;
    assign byte_length = res.byte_length;
    assign word_data   = res.word_data;
    assign reply_ok    = res.reply_ok;
    assign last_of_run = res.last_of_run;

`ifndef SYNTHESIS
    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !room) |=> (item_valid_reg && $stable(item_reg)))
        else $error("stalled input item lost");
`endif

endmodule

// ----- rtl/smcp_parser.sv -----
module smcp_parser
    import smcp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  fire,
    input  item_t item,
    output push_t push
);

    phase_t      phase_reg,   phase_next;
    pending_t    pending_reg, pending_next;
    logic [31:0] addr_reg,    addr_next;
    logic [15:0] rem_reg,     rem_next;
    logic [31:0] word_reg,    word_next;

    function automatic result_t mk_result(action_t act, logic [31:0] addr,
                                          logic [15:0] len, logic [31:0] word,
                                          logic ok, logic last);
        result_t r;
        r.action      = act;
        r.mem_address = addr;
        r.byte_length = len;
        r.word_data   = word;
        r.reply_ok    = ok;
        r.last_of_run = last;
        return r;
    endfunction

    always_comb
    begin
        logic [7:0] b;
        b            = item.rx_byte;
        phase_next   = phase_reg;
        pending_next = pending_reg;
        addr_next    = addr_reg;
        rem_next     = rem_reg;
        word_next    = word_reg;
        push         = '0;

        if (item.req_type) begin
            unique case (pending_reg)
                OP_ERASE:
                begin
                    pending_next = OP_NONE;
                    push.count   = 2'd1;
                    push.r0      = mk_result(ACT_REPLY, '0, '0, '0, item.flash_ok, 1'b1);
                end
                OP_PROGRAM:
                begin
                    pending_next = OP_NONE;
                    if (!item.flash_ok) begin
                        phase_next = PH_IDLE;
                        push.count = 2'd2;
                        push.r0    = mk_result(ACT_LOCK, '0, '0, '0, 1'b0, 1'b0);
                        push.r1    = mk_result(ACT_REPLY, '0, '0, '0, 1'b0, 1'b1);
                    end else begin
                        addr_next = addr_reg + 32'd4;
                        if (rem_reg <= 16'd4) begin
                            rem_next   = '0;
                            phase_next = PH_IDLE;
                            push.count = 2'd2;
                            push.r0    = mk_result(ACT_LOCK, '0, '0, '0, 1'b0, 1'b0);
                            push.r1    = mk_result(ACT_REPLY, '0, '0, '0, 1'b1, 1'b1);
                        end else begin
                            rem_next   = rem_reg - 16'd4;
                            phase_next = PH_WR0;
                        end
                    end
                end
                default: pending_next = OP_NONE;
            endcase
        end else if (pending_reg != OP_ERASE && pending_reg != OP_PROGRAM) begin
            unique case (phase_reg)
                PH_SYNC:  phase_next = (b == CHAR_SYNC2) ? PH_ADDR0 : PH_IDLE;
                PH_ADDR0:
                begin
                    addr_next  = {b, 24'd0};
                    phase_next = PH_ADDR1;
                end
                PH_ADDR1:
                begin
                    addr_next  = addr_reg | {8'd0, b, 16'd0};
                    phase_next = PH_ADDR2;
                end
                PH_ADDR2:
                begin
                    addr_next  = addr_reg | {16'd0, b, 8'd0};
                    phase_next = PH_ADDR3;
                end
                PH_ADDR3:
                begin
                    addr_next  = addr_reg | {24'd0, b};
                    phase_next = PH_LEN0;
                end
                PH_LEN0:
                begin
                    rem_next   = {b, 8'd0};
                    phase_next = PH_LEN1;
                end
                PH_LEN1:
                begin
                    rem_next   = rem_reg | {8'd0, b};
                    phase_next = PH_CMD;
                end
                PH_CMD:
                begin
                    // unknown command bytes leave the phase alone
                    if (b == CHAR_READ) begin
                        phase_next = PH_IDLE;
                        push.count = 2'd1;
                        push.r0    = mk_result(ACT_READ, addr_reg, rem_reg, '0, 1'b0, 1'b1);
                    end else if (b == CHAR_RESET) begin
                        phase_next = PH_IDLE;
                        push.count = 2'd1;
                        push.r0    = mk_result(ACT_RESET, '0, '0, '0, 1'b0, 1'b1);
                    end else if (b == CHAR_ERASE) begin
                        phase_next   = PH_IDLE;
                        pending_next = OP_ERASE;
                        push.count   = 2'd2;
                        push.r0      = mk_result(ACT_UNLOCK, '0, '0, '0, 1'b0, 1'b0);
                        push.r1      = mk_result(ACT_ERASE, addr_reg, '0, '0, 1'b0, 1'b1);
                    end else if (b == CHAR_WRITE) begin
                        phase_next = PH_WR0;
                        push.count = 2'd1;
                        push.r0    = mk_result(ACT_UNLOCK, '0, '0, '0, 1'b0, 1'b1);
                    end
                end
                PH_WR0:
                begin
                    word_next  = {24'd0, b};
                    phase_next = PH_WR1;
                end
                PH_WR1:
                begin
                    word_next  = word_reg | {16'd0, b, 8'd0};
                    phase_next = PH_WR2;
                end
                PH_WR2:
                begin
                    word_next  = word_reg | {8'd0, b, 16'd0};
                    phase_next = PH_WR3;
                end
                PH_WR3:
                begin
                    // phase holds here until the program status comes back
                    word_next    = word_reg | {b, 24'd0};
                    pending_next = OP_PROGRAM;
                    push.count   = 2'd1;
                    push.r0      = mk_result(ACT_PROGRAM, addr_reg, '0,
                                             word_reg | {b, 24'd0}, 1'b0, 1'b1);
                end
                default:  phase_next = (b == CHAR_SYNC1) ? PH_SYNC : PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg   <= PH_IDLE;
            pending_reg <= OP_NONE;
            addr_reg    <= '0;
            rem_reg     <= '0;
            word_reg    <= '0;
        end else if (fire) begin
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
            addr_reg    <= addr_next;
            rem_reg     <= rem_next;
            word_reg    <= word_next;
        end
    end

`ifndef SYNTHESIS
    a_busy_byte_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !item.req_type && pending_reg != OP_NONE) |=>
            ($stable(phase_reg) && $stable(addr_reg) && $stable(word_reg)))
        else $error("byte changed parser state while a status was pending");
    a_last_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |-> (!push.r0.last_of_run && push.r1.last_of_run))
        else $error("last_of_run misplaced in a two-result transfer");
    a_program_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg == OP_PROGRAM) |-> (phase_reg == PH_WR3))
        else $error("program pending outside the last write byte phase");
`endif

endmodule

// ----- rtl/smcp_result_queue.sv -----
module smcp_result_queue
    import smcp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_en,
    input  push_t   push,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    result_t               entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wp_reg, rp_reg;
    logic [QUEUE_CW-1:0]   count_reg, count_next;
    logic [1:0]            n_push;
    logic                  pop;

    assign room      = (count_reg <= QUEUE_CW'(QUEUE_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rp_reg];
    assign pop       = out_valid && out_ready;
    assign n_push    = push_en ? push.count : 2'd0;
    assign count_next = count_reg + QUEUE_CW'(n_push) - QUEUE_CW'(pop);

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0) begin
            entry_reg[wp_reg] <= push.r0;
        end
        if (n_push == 2'd2) begin
            entry_reg[wp_reg + QUEUE_AW'(1)] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end else begin
            wp_reg    <= wp_reg + QUEUE_AW'(n_push);
            rp_reg    <= rp_reg + QUEUE_AW'(pop);
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("result queue overflow");
    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (n_push != 2'd0) |-> room)
        else $error("results pushed without room");
`endif

endmodule
